[hw/rtl/isp_pkg.sv]
// Shared constants and types for the interpolating sample player.
`timescale 1ns / 1ps

package isp_pkg;

  localparam int NumChannels = 2;
  localparam int SampleDepth = 65536;
  localparam int RamAw       = $clog2(SampleDepth);
  localparam int ChW         = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int FracW = 12;
  localparam int PosW  = 18;
  localparam int LenW  = 17;
  localparam int BaseW = 20;

  localparam logic [15:0] SpeedReset = 16'd4096;
  localparam logic [15:0] GainReset  = 16'd16384;

  // input item queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // result queue
  localparam int OutDepth = 2;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ARM  = 2'd1,
    OP_PLAY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_TICK_SPEED = 2'd0,
    CFG_GAIN       = 2'd1,
    CFG_LOOP       = 2'd2,
    CFG_LENGTH     = 2'd3
  } cfg_e;

  typedef struct packed {
    op_e                op;
    logic [15:0]        addr;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               finished;
  } result_t;

endpackage

[hw/rtl/isp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module isp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/isp_front.sv]
// Front end: accepts input items, drops ignored ones, queues the rest.
`timescale 1ns / 1ps

module isp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        load_address_i,
  input  logic signed [15:0] load_value_i,
  output isp_pkg::head_t     head_o,
  input  logic               pop_i
);

  isp_pkg::item_t             q_mem [isp_pkg::QDepth];
  logic [isp_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [isp_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [isp_pkg::QCntW-1:0]  count_q, count_d;
  logic                       accept;
  logic                       keep;
  isp_pkg::item_t             item;

  assign full_o = (count_q == isp_pkg::QCntW'(isp_pkg::QDepth));
  assign accept = push_i && !full_o;

  always_comb begin
    item.op    = isp_pkg::OP_PLAY;
    item.addr  = load_address_i;
    item.value = load_value_i;
    keep       = 1'b0;
    case (operation_i)
      isp_pkg::OP_LOAD: begin
        item.op = isp_pkg::OP_LOAD;
        keep    = (32'(load_address_i) < 32'(isp_pkg::SampleDepth));
      end
      isp_pkg::OP_ARM: begin
        item.op = isp_pkg::OP_ARM;
        keep    = 1'b1;
      end
      isp_pkg::OP_PLAY: begin
        item.op = isp_pkg::OP_PLAY;
        keep    = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept && keep) begin
      wr_ptr_d = wr_ptr_q + isp_pkg::QPtrW'(1);
    end
    if (pop_i && head_o.valid) begin
      rd_ptr_d = rd_ptr_q + isp_pkg::QPtrW'(1);
    end
    count_d = count_q + isp_pkg::QCntW'(accept && keep)
                      - isp_pkg::QCntW'(pop_i && head_o.valid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

endmodule

[hw/rtl/isp_back.sv]
// Back end: config registers, sample store, playback state and interpolation.
`timescale 1ns / 1ps

module isp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  isp_pkg::head_t       head_i,
  output logic                 pop_o,
  input  logic                 out_space_i,
  output logic                 res_push_o,
  output isp_pkg::result_t     res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_MULF,
    ST_MULG,
    ST_RND,
    ST_PUSH
  } state_e;

  state_e                     state_q;

  logic [15:0]                tick_speed_q;
  logic [15:0]                gain_q;
  logic                       loop_q;
  logic [isp_pkg::LenW-1:0]   length_q;

  logic [isp_pkg::PosW-1:0]   pos_q;
  logic [isp_pkg::FracW-1:0]  frac_q;
  logic [isp_pkg::ChW-1:0]    ch_q;
  logic                       armed_q;
  logic                       ended_q;

  logic [isp_pkg::BaseW-1:0]  base_q;
  logic signed [15:0]         lower_q;
  logic signed [16:0]         diff_q;
  logic signed [27:0]         interp_q;
  logic signed [44:0]         scaled_q;
  isp_pkg::result_t           res_q;

  logic [isp_pkg::BaseW-1:0]  base_d;
  logic [isp_pkg::BaseW-1:0]  up_addr;
  logic                       lo_ok, hi_ok;
  logic [isp_pkg::RamAw-1:0]  ram_raddr;
  logic [15:0]                ram_rdata;
  logic                       ram_we;
  logic                       active;
  logic signed [15:0]         upper;
  logic signed [29:0]         prod_f;
  logic signed [30:0]         interp_d;
  logic signed [44:0]         rnd;
  logic signed [15:0]         sat;
  logic [16:0]                acc;
  logic [isp_pkg::PosW-1:0]   pos_adv;
  logic                       last_ch;
  logic                       at_end;

  assign active  = armed_q && !ended_q;
  assign base_d  = isp_pkg::BaseW'(pos_q) + isp_pkg::BaseW'(ch_q);
  assign up_addr = base_q + isp_pkg::BaseW'(isp_pkg::NumChannels);
  assign lo_ok   = (32'(base_q) < 32'(length_q)) &&
                   (32'(base_q) < 32'(isp_pkg::SampleDepth));
  assign hi_ok   = (32'(up_addr) < 32'(length_q)) &&
                   (32'(up_addr) < 32'(isp_pkg::SampleDepth));

  assign ram_raddr = (state_q == ST_IDLE) ? isp_pkg::RamAw'(base_d)
                                          : isp_pkg::RamAw'(up_addr);
  assign ram_we    = (state_q == ST_IDLE) && head_i.valid &&
                     (head_i.item.op == isp_pkg::OP_LOAD);

  isp_ram #(
    .Width(16),
    .Depth(isp_pkg::SampleDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(isp_pkg::RamAw'(head_i.item.addr)),
    .wdata_i(head_i.item.value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    pop_o = 1'b0;
    if (state_q == ST_IDLE && head_i.valid) begin
      pop_o = (head_i.item.op != isp_pkg::OP_PLAY) || out_space_i;
    end
  end

  assign res_push_o = (state_q == ST_PUSH);
  assign res_o      = res_q;

  // datapath
  assign upper    = hi_ok ? $signed(ram_rdata) : 16'sd0;
  assign prod_f   = diff_q * $signed({1'b0, frac_q});
  assign interp_d = 31'(prod_f) + (31'(lower_q) <<< isp_pkg::FracW);
  assign rnd      = (scaled_q + 45'sd33554432) >>> 26;

  always_comb begin
    if (rnd > 45'sd32767) begin
      sat = 16'sd32767;
    end else if (rnd < -45'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = rnd[15:0];
    end
  end

  // frame advance
  assign last_ch = (32'(ch_q) + 32'd1 >= 32'(isp_pkg::NumChannels));
  assign acc     = 17'(frac_q) + 17'(tick_speed_q);
  assign pos_adv = isp_pkg::PosW'(pos_q + isp_pkg::PosW'(acc[16:12]) *
                                  isp_pkg::PosW'(isp_pkg::NumChannels));
  assign at_end  = ({pos_adv, acc[11:0]} >= {1'b0, length_q, 12'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_speed_q <= isp_pkg::SpeedReset;
      gain_q       <= isp_pkg::GainReset;
      loop_q       <= 1'b0;
      length_q     <= '0;
      pos_q        <= '0;
      frac_q       <= '0;
      ch_q         <= '0;
      armed_q      <= 1'b0;
      ended_q      <= 1'b1;
      base_q       <= '0;
      lower_q      <= '0;
      diff_q       <= '0;
      interp_q     <= '0;
      scaled_q     <= '0;
      res_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          isp_pkg::CFG_TICK_SPEED: tick_speed_q <= cfg_data_i[15:0];
          isp_pkg::CFG_GAIN:       gain_q       <= cfg_data_i[15:0];
          isp_pkg::CFG_LOOP:       loop_q       <= cfg_data_i[0];
          isp_pkg::CFG_LENGTH:     length_q     <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (head_i.valid) begin
            case (head_i.item.op)
              isp_pkg::OP_ARM: begin
                armed_q <= 1'b1;
                ended_q <= 1'b0;
                pos_q   <= '0;
                frac_q  <= '0;
                ch_q    <= '0;
              end
              isp_pkg::OP_PLAY: begin
                if (out_space_i) begin
                  if (active) begin
                    base_q  <= base_d;
                    state_q <= ST_LO;
                  end else begin
                    res_q.sample   <= '0;
                    res_q.finished <= ended_q;
                    state_q        <= ST_PUSH;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_LO: begin
          lower_q <= lo_ok ? $signed(ram_rdata) : 16'sd0;
          state_q <= ST_HI;
        end
        ST_HI: begin
          diff_q  <= 17'(upper) - 17'(lower_q);
          state_q <= ST_MULF;
        end
        ST_MULF: begin
          interp_q <= interp_d[27:0];
          state_q  <= ST_MULG;
        end
        ST_MULG: begin
          scaled_q <= interp_q * $signed({1'b0, gain_q});
          if (last_ch) begin
            ch_q <= '0;
            if (at_end && loop_q) begin
              pos_q  <= '0;
              frac_q <= '0;
            end else begin
              pos_q  <= pos_adv;
              frac_q <= acc[11:0];
              if (at_end) begin
                ended_q <= 1'b1;
              end
            end
          end else begin
            ch_q <= ch_q + isp_pkg::ChW'(1);
          end
          state_q <= ST_RND;
        end
        ST_RND: begin
          res_q.sample   <= sat;
          res_q.finished <= ended_q;
          state_q        <= ST_PUSH;
        end
        ST_PUSH: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/isp_out.sv]
// Result queue between the back end and the result ports.
`timescale 1ns / 1ps

module isp_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  isp_pkg::result_t     res_i,
  output logic                 space_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output isp_pkg::result_t     res_o
);

  isp_pkg::result_t             q_mem [isp_pkg::OutDepth];
  logic [isp_pkg::OutPtrW-1:0]  wr_ptr_q;
  logic [isp_pkg::OutPtrW-1:0]  rd_ptr_q;
  logic [isp_pkg::OutCntW-1:0]  count_q;
  logic                         do_pop;

  assign empty_o = (count_q == '0);
  assign space_o = (count_q != isp_pkg::OutCntW'(isp_pkg::OutDepth));
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + isp_pkg::OutPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + isp_pkg::OutPtrW'(1);
      end
      count_q <= count_q + isp_pkg::OutCntW'(push_i) - isp_pkg::OutCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

[hw/rtl/interpolating_sample_player_top.sv]
// Top level of the interpolating sample player.
// Items enter a four-deep queue and are carried out one at a time by the back end. An active
// play steps through its states in order: the start state reads the lower word, the next reads
// the upper word of the single-read-port sample store, then come the difference, the fraction
// multiply, the gain multiply, rounding and the result push. The next item is not taken until
// the play has pushed its result. A play while idle or ended goes straight to the result push.
// Results wait in a two-deep queue; a play is started only while that queue has room.
// Configuration writes take effect on the next edge and are to be made while the block is
// idle. The sample store has no reset.
`timescale 1ns / 1ps

module interpolating_sample_player_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        load_address_i,
  input  logic signed [15:0] load_value_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [15:0] sample_out_o,
  output logic               finished_o
);

  isp_pkg::head_t   head;
  logic             head_pop;
  logic             out_space;
  logic             res_push;
  isp_pkg::result_t res_back;
  isp_pkg::result_t res_out;

  isp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .operation_i   (operation_i),
    .load_address_i(load_address_i),
    .load_value_i  (load_value_i),
    .head_o        (head),
    .pop_i         (head_pop)
  );

  isp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (head_pop),
    .out_space_i(out_space),
    .res_push_o (res_push),
    .res_o      (res_back)
  );

  isp_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_back),
    .space_o(out_space),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .res_o  (res_out)
  );

  assign sample_out_o = res_out.sample;
  assign finished_o   = res_out.finished;

endmodule

[hw/rtl/isp_checker.sv]
// Port-level assertions for the interpolating sample player, bound to the top level.
`timescale 1ns / 1ps

module isp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push_i,
  input logic               full_o,
  input logic               pop_i,
  input logic               empty_o,
  input logic signed [15:0] sample_out_o,
  input logic               finished_o
);

  a_reset_queues: assert property (@(posedge clk_i)
    !rst_ni |=> (empty_o && !full_o))
    else $error("queues not clear in reset");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("input queue filled without an item");

  a_empty_needs_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_o) |-> $past(pop_i))
    else $error("result dropped without pop");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(sample_out_o) && $stable(finished_o)))
    else $error("waiting result changed");

endmodule

bind interpolating_sample_player_top isp_checker u_checker (.*);

[bench/interpolating_sample_player_top_tb.sv]
// Testbench for the interpolating sample player: directed and random items against a predictor.
`timescale 1ns / 1ps

module interpolating_sample_player_top_tb;
  import isp_pkg::*;

  localparam logic [1:0] OpUnused      = 2'd3;
  localparam int         SettleCycles  = 40;
  localparam int         WatchdogLimit = 2000;
  localparam int         FillWords     = 128;
  localparam longint     RoundHalf     = 64'sd33554432;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_index_i    = '0;
  logic [16:0]        cfg_data_i     = '0;
  logic               push_i         = 1'b0;
  logic [1:0]         operation_i    = '0;
  logic [15:0]        load_address_i = '0;
  logic signed [15:0] load_value_i   = '0;
  logic               pop_i          = 1'b0;
  logic               full_o;
  logic               empty_o;
  logic signed [15:0] sample_out_o;
  logic               finished_o;

  interpolating_sample_player_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .operation_i    (operation_i),
    .load_address_i (load_address_i),
    .load_value_i   (load_value_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .sample_out_o   (sample_out_o),
    .finished_o     (finished_o)
  );

  // predictor state
  logic signed [15:0] sample_mem     [SampleDepth];
  bit                 sample_written [SampleDepth];
  int unsigned        play_pos, play_frac, play_chan;
  bit                 play_armed, play_ended;
  int unsigned        rate_q, gain_q, length_q;
  bit                 loop_q;
  result_t            expected_samples [$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  pop_stall = 0;
  bit  idle_on = 1'b1;
  result_t want_r;

  initial begin
    play_pos   = 0;
    play_frac  = 0;
    play_chan  = 0;
    play_armed = 1'b0;
    play_ended = 1'b1;
    rate_q     = SpeedReset;
    gain_q     = GainReset;
    length_q   = 0;
    loop_q     = 1'b0;
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint stored_word(int unsigned addr);
    if (addr >= length_q || addr >= SampleDepth) return 0;
    return longint'(sample_mem[addr]);
  endfunction

  function automatic bit reads_unwritten(int unsigned addr);
    return addr < length_q && addr < SampleDepth && !sample_written[addr];
  endfunction

  function automatic bit play_reads_unwritten();
    int unsigned base;
    if (!(play_armed && !play_ended)) return 1'b0;
    base = play_pos + play_chan;
    return reads_unwritten(base) || (play_frac != 0 && reads_unwritten(base + NumChannels));
  endfunction

  function automatic void restart_playback();
    play_armed = 1'b1;
    play_ended = 1'b0;
    play_pos   = 0;
    play_frac  = 0;
    play_chan  = 0;
  endfunction

  function automatic void advance_phase();
    int unsigned acc;
    play_chan++;
    if (play_chan >= NumChannels) begin
      acc       = play_frac + rate_q;
      play_pos  = (play_pos + (acc >> FracW) * NumChannels) & 32'h3FFFF;
      play_frac = acc & 32'hFFF;
      play_chan = 0;
      if (play_pos * 4096 + play_frac >= length_q * 4096) begin
        play_ended = 1'b1;
        if (loop_q) restart_playback();
      end
    end
  endfunction

  function automatic result_t play_sample();
    result_t     r;
    int unsigned base;
    longint      lower, upper, acc, scaled, rounded;
    r.sample = '0;
    if (play_armed && !play_ended) begin
      base  = play_pos + play_chan;
      lower = stored_word(base);
      acc   = lower * 4096;
      if (play_frac != 0) begin
        upper = stored_word(base + NumChannels);
        acc   = acc + (upper - lower) * longint'(play_frac);
      end
      scaled  = acc * longint'(gain_q);
      rounded = (scaled + RoundHalf) >>> 26;
      if (rounded > 32767) rounded = 32767;
      else if (rounded < -32768) rounded = -32768;
      r.sample = rounded[15:0];
      advance_phase();
    end
    r.finished = play_ended;
    return r;
  endfunction

  function automatic void model_item(logic [1:0] op, logic [15:0] addr,
                                     logic signed [15:0] value);
    case (op)
      OP_LOAD: begin
        if (addr < SampleDepth) begin
          sample_mem[addr]     = value;
          sample_written[addr] = 1'b1;
        end
      end
      OP_ARM:  restart_playback();
      OP_PLAY: expected_samples.push_back(play_sample());
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                           input logic signed [15:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i         <= 1'b1;
    operation_i    <= op;
    load_address_i <= addr;
    load_value_i   <= value;
    do @(posedge clk_i); while (full_o);
    model_item(op, addr, value);
  endtask

  task automatic send_op(input logic [1:0] op);
    send_item(op, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_for_results();
    push_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [16:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_TICK_SPEED: rate_q   = data[15:0];
      CFG_GAIN:       gain_q   = data[15:0];
      CFG_LOOP:       loop_q   = data[0];
      CFG_LENGTH:     length_q = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] speed, input logic [15:0] gain,
                            input logic loop_en, input logic [16:0] len);
    wait_for_results();
    write_reg(CFG_TICK_SPEED, 17'(speed));
    write_reg(CFG_GAIN, 17'(gain));
    write_reg(CFG_LOOP, 17'(loop_en));
    write_reg(CFG_LENGTH, len);
  endtask

  // play before any arm, and the unused operation
  task automatic test_idle_player();
    send_op(OP_PLAY);
    send_op(OpUnused);
  endtask

  task automatic test_unit_speed();
    send_item(OP_LOAD, 16'd0, 16'sd32767);
    send_item(OP_LOAD, 16'd1, -16'sd32768);
    send_item(OP_LOAD, 16'd2, -16'sd32768);
    send_item(OP_LOAD, 16'd3, 16'sd32767);
    send_item(OP_LOAD, 16'hFFFF, 16'sh1234);
    set_config(16'd4096, 16'd16384, 1'b0, 17'd4);
    send_op(OP_ARM);
    repeat (5) send_op(OP_PLAY);
  endtask

  // half speed with full gain: interpolation, reads past length, saturation, loop restart
  task automatic test_fractional_and_saturation();
    set_config(16'h0800, 16'hFFFF, 1'b1, 17'd4);
    send_op(OP_ARM);
    repeat (9) send_op(OP_PLAY);
  endtask

  task automatic test_zero_speed_and_length();
    set_config(16'd0, 16'd16384, 1'b0, 17'd4);
    send_op(OP_ARM);
    repeat (3) send_op(OP_PLAY);
    set_config(16'd4096, 16'd16384, 1'b0, 17'd0);
    send_op(OP_ARM);
    send_op(OP_PLAY);
  endtask

  task automatic test_random_playback();
    logic [15:0] speed, gain;
    logic [16:0] len;
    int          r;
    for (int a = 0; a < FillWords; a++) send_item(OP_LOAD, 16'(a), 16'($urandom));
    for (int p = 0; p < 9; p++) begin
      r     = $urandom_range(0, 99);
      speed = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : (r < 50) ? 16'd4096
                                : 16'($urandom_range(0, 12000));
      r     = $urandom_range(0, 99);
      gain  = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom);
      r     = $urandom_range(0, 99);
      len   = (r < 10) ? 17'd0 : (r < 20) ? 17'd65536 : 17'($urandom_range(1, FillWords));
      if (p == 0) begin
        speed = 16'hFFFF;
        gain  = 16'd0;
      end
      if (p == 1) begin
        len  = 17'd65536;
        gain = 16'hFFFF;
      end
      set_config(speed, gain, 1'($urandom), len);
      idle_on = (p != 4);
      send_op(OP_ARM);
      for (int i = 0; i < 80; i++) begin
        if (p == 2 && i == 40) wait_for_results();
        r = $urandom_range(0, 99);
        if (r < 62) begin
          if (play_reads_unwritten()) send_op(OP_ARM);
          else send_op(OP_PLAY);
        end else if (r < 74) begin
          send_item(OP_LOAD, 16'($urandom_range(0, FillWords - 1)), 16'($urandom));
        end else if (r < 82) begin
          send_op(OP_LOAD);
        end else if (r < 94) begin
          send_op(OP_ARM);
        end else begin
          send_op(OpUnused);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // result side: check every popped result and stall pop at random
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: sample_out %0d finished %0b", sample_out_o, finished_o);
        fail_count++;
      end else begin
        want_r = expected_samples.pop_front();
        if (sample_out_o !== want_r.sample) begin
          $error("sample_out: expected %0d, actual %0d", want_r.sample, sample_out_o);
          fail_count++;
        end
        if (finished_o !== want_r.finished) begin
          $error("finished: expected %0b, actual %0b", want_r.finished, finished_o);
          fail_count++;
        end
      end
    end
    if (pop_stall == 0) pop_stall = pick_gap();
    if (pop_stall > 0) begin
      pop_i <= 1'b0;
      pop_stall--;
    end else begin
      pop_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_player();
    test_unit_speed();
    test_fractional_and_saturation();
    test_zero_speed_and_length();
    test_random_playback();
    wait_for_results();
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
